// File: rtl/core/ips_psp_pkg.sv
// Shared types, result codes and header constants for the IPS patch stream parser.
`default_nettype none

package ips_psp_pkg;

    // result kinds
    localparam logic [2:0] KIND_WRITE     = 3'd0;
    localparam logic [2:0] KIND_FILL      = 3'd1;
    localparam logic [2:0] KIND_FINISH    = 3'd2;
    localparam logic [2:0] KIND_BAD_HDR   = 3'd3;
    localparam logic [2:0] KIND_CUT_SHORT = 3'd4;

    localparam logic [23:0] EOF_MARK    = 24'h454F46;
    localparam logic [2:0]  HDR_LEN     = 3'd5;
    localparam logic [2:0]  ADDR_BYTES  = 3'd3;
    localparam logic [2:0]  LEN_BYTES   = 3'd2;
    localparam logic [2:0]  TRAIL_BYTES = 3'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] target_address;
        logic [7:0]  fill_value;
        logic [15:0] run_length;
        logic [24:0] needed_size;
        logic        cut_valid;
        logic [23:0] cut_size;
        logic        is_last;
    } psp_result_t;

    // up to two results produced by one accepted byte, packed in order
    typedef struct packed {
        logic [1:0]  count;
        psp_result_t first;
        psp_result_t second;
    } psp_push_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h50; // P
            3'd1:    c = 8'h41; // A
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h43; // C
            3'd4:    c = 8'h48; // H
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ips_psp_parser.sv
// Byte-level parser state and per-byte result generation.
`default_nettype none

module ips_psp_parser
    import ips_psp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_accept,
    input  wire logic [7:0] patch_byte,
    input  wire logic      final_byte,
    output psp_push_t      push
);

    localparam logic [3:0] PH_HEADER   = 4'd0;
    localparam logic [3:0] PH_ADDR     = 4'd1;
    localparam logic [3:0] PH_LEN      = 4'd2;
    localparam logic [3:0] PH_DATA     = 4'd3;
    localparam logic [3:0] PH_RUNLEN   = 4'd4;
    localparam logic [3:0] PH_RUNVAL   = 4'd5;
    localparam logic [3:0] PH_TRAILER  = 4'd6;
    localparam logic [3:0] PH_TAILDONE = 4'd7;
    localparam logic [3:0] PH_SKIP     = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [23:0] rec_addr_reg, rec_addr_next;
    logic [15:0] rec_len_reg, rec_len_next;
    logic [15:0] data_off_reg, data_off_next;
    logic [15:0] fill_cnt_reg, fill_cnt_next;
    logic [24:0] size_needed_reg, size_needed_next;
    logic [23:0] trailer_reg, trailer_next;

    psp_result_t rec_res, fin_res;
    logic        rec_v, fin_v;
    logic        grow_en;
    logic [15:0] grow_len;
    logic [24:0] end_sum;
    logic [2:0]  idx_inc;
    logic [15:0] off_inc;

    assign idx_inc = byte_index_reg + 3'd1;
    assign off_inc = data_off_reg + 16'd1;
    assign end_sum = {1'b0, rec_addr_reg} + {9'b0, grow_len};

    always_comb begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        rec_addr_next    = rec_addr_reg;
        rec_len_next     = rec_len_reg;
        data_off_next    = data_off_reg;
        fill_cnt_next    = fill_cnt_reg;
        size_needed_next = size_needed_reg;
        trailer_next     = trailer_reg;
        rec_res          = '0;
        fin_res          = '0;
        rec_v            = 1'b0;
        fin_v            = 1'b0;
        grow_en          = 1'b0;
        grow_len         = rec_len_reg;

        if (in_accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (byte_index_reg >= HDR_LEN || patch_byte != hdr_char(byte_index_reg)) begin
                        rec_v        = 1'b1;
                        rec_res.kind = KIND_BAD_HDR;
                        phase_next   = PH_SKIP;
                    end else if (idx_inc == HDR_LEN) begin
                        byte_index_next = '0;
                        phase_next      = PH_ADDR;
                    end else begin
                        byte_index_next = idx_inc;
                    end
                end
                PH_ADDR: begin
                    rec_addr_next = {rec_addr_reg[15:0], patch_byte};
                    if (idx_inc >= ADDR_BYTES) begin
                        byte_index_next = '0;
                        if (rec_addr_next == EOF_MARK) begin
                            trailer_next = '0;
                            phase_next   = PH_TRAILER;
                        end else begin
                            rec_len_next = '0;
                            phase_next   = PH_LEN;
                        end
                    end else begin
                        byte_index_next = idx_inc;
                    end
                end
                PH_LEN: begin
                    rec_len_next = {rec_len_reg[7:0], patch_byte};
                    if (idx_inc >= LEN_BYTES) begin
                        byte_index_next = '0;
                        if (rec_len_next != 16'd0) begin
                            data_off_next = '0;
                            phase_next    = PH_DATA;
                        end else begin
                            fill_cnt_next = '0;
                            phase_next    = PH_RUNLEN;
                        end
                    end else begin
                        byte_index_next = idx_inc;
                    end
                end
                PH_DATA: begin
                    rec_v                  = 1'b1;
                    rec_res.kind           = KIND_WRITE;
                    rec_res.target_address = rec_addr_reg + {8'b0, data_off_reg};
                    rec_res.fill_value     = patch_byte;
                    data_off_next          = off_inc;
                    if (off_inc == rec_len_reg) begin
                        grow_en    = 1'b1;
                        phase_next = PH_ADDR;
                    end
                end
                PH_RUNLEN: begin
                    fill_cnt_next = {fill_cnt_reg[7:0], patch_byte};
                    if (idx_inc >= LEN_BYTES) begin
                        byte_index_next = '0;
                        phase_next      = PH_RUNVAL;
                    end else begin
                        byte_index_next = idx_inc;
                    end
                end
                PH_RUNVAL: begin
                    rec_v                  = 1'b1;
                    rec_res.kind           = KIND_FILL;
                    rec_res.target_address = rec_addr_reg;
                    rec_res.fill_value     = patch_byte;
                    rec_res.run_length     = fill_cnt_reg;
                    grow_en                = 1'b1;
                    grow_len               = fill_cnt_reg;
                    phase_next             = PH_ADDR;
                end
                PH_TRAILER: begin
                    trailer_next = {trailer_reg[15:0], patch_byte};
                    if (idx_inc >= TRAIL_BYTES) begin
                        byte_index_next = '0;
                        phase_next      = PH_TAILDONE;
                    end else begin
                        byte_index_next = idx_inc;
                    end
                end
                default: ;
            endcase

            if (grow_en && end_sum > size_needed_reg) begin
                size_needed_next = end_sum;
            end

            if (final_byte) begin
                if (phase_next == PH_TRAILER) begin
                    fin_v               = 1'b1;
                    fin_res.kind        = KIND_FINISH;
                    fin_res.needed_size = size_needed_next;
                end else if (phase_next == PH_TAILDONE) begin
                    fin_v               = 1'b1;
                    fin_res.kind        = KIND_FINISH;
                    fin_res.needed_size = size_needed_next;
                    fin_res.cut_valid   = 1'b1;
                    fin_res.cut_size    = trailer_next;
                end else if (phase_next <= PH_RUNVAL) begin
                    fin_v        = 1'b1;
                    fin_res.kind = KIND_CUT_SHORT;
                end
                // end of file: parser returns to its reset state
                phase_next       = PH_HEADER;
                byte_index_next  = '0;
                rec_addr_next    = '0;
                rec_len_next     = '0;
                data_off_next    = '0;
                fill_cnt_next    = '0;
                size_needed_next = '0;
                trailer_next     = '0;
            end
        end
    end

    always_comb begin
        push = '0;
        if (rec_v && fin_v) begin
            push.count          = 2'd2;
            push.first          = rec_res;
            push.second         = fin_res;
            push.second.is_last = 1'b1;
        end else if (rec_v) begin
            push.count         = 2'd1;
            push.first         = rec_res;
            push.first.is_last = 1'b1;
        end else if (fin_v) begin
            push.count         = 2'd1;
            push.first         = fin_res;
            push.first.is_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            byte_index_reg  <= '0;
            rec_addr_reg    <= '0;
            rec_len_reg     <= '0;
            data_off_reg    <= '0;
            fill_cnt_reg    <= '0;
            size_needed_reg <= '0;
            trailer_reg     <= '0;
        end else begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            rec_addr_reg    <= rec_addr_next;
            rec_len_reg     <= rec_len_next;
            data_off_reg    <= data_off_next;
            fill_cnt_reg    <= fill_cnt_next;
            size_needed_reg <= size_needed_next;
            trailer_reg     <= trailer_next;
        end
    end

`ifndef ASSERT_OFF
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_SKIP)
        else $error("parser phase out of range");

    a_final_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && final_byte) |=> (phase_reg == PH_HEADER && byte_index_reg == 3'd0
                                       && size_needed_reg == 25'd0))
        else $error("parser not reset after final byte");

    a_bad_hdr_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0 && push.first.kind == KIND_BAD_HDR) |-> phase_reg == PH_HEADER)
        else $error("bad header result outside header phase");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ips_psp_outq.sv
// Four-entry result queue taking up to two results per cycle and draining one per cycle while out_ready is high.
`default_nettype none

module ips_psp_outq
    import ips_psp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire psp_push_t push,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output psp_result_t out_result
);

    psp_result_t entry_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;
    logic [1:0]  wr_ptr_inc;

    // keep room for the worst case of two results from one byte
    assign in_ready   = (count_reg <= 3'd2);
    assign out_valid  = (count_reg != 3'd0);
    assign out_result = entry_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + 2'd1;

    assign wr_ptr_next = wr_ptr_reg + push.count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push.count} - {2'b0, pop};

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue count moved without transaction");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        ((wr_ptr_reg - rd_ptr_reg) == count_reg[1:0]))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ips_patch_stream_parser_unit.sv
// Top level of the IPS patch stream parser: byte parser plus result queue.
//
//  channel | direction | ports                          | handshake
//  s_      | in        | s_patch_byte, s_final_byte     | s_valid / s_ready
//  m_      | out       | m_kind .. m_is_last            | m_valid / m_ready
//
// One byte accepted per cycle while s_ready is high; its results are written into the
// queue at the accepting edge and show on m_ behind any results already queued.
// A byte gives zero, one or two results; the queue drains one per cycle while m_ready is high.
// s_ready drops when fewer than two queue entries are free (four entries).
// aresetn is synchronous, active low; clears parser state and empties the queue.
// A stalled m_ready fills the queue and then stalls s_ready.
`default_nettype none

module ips_patch_stream_parser_unit
    import ips_psp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_patch_byte,
    input  wire logic        s_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [23:0]      m_target_address,
    output logic [7:0]       m_fill_value,
    output logic [15:0]      m_run_length,
    output logic [24:0]      m_needed_size,
    output logic             m_cut_valid,
    output logic [23:0]      m_cut_size,
    output logic             m_is_last
);

    psp_push_t   push;
    psp_result_t res;
    logic        accept;

    assign accept = s_valid && s_ready;

    ips_psp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (accept),
        .patch_byte (s_patch_byte),
        .final_byte (s_final_byte),
        .push       (push)
    );

    ips_psp_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .in_ready   (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (res)
    );

    assign m_kind           = res.kind;
    assign m_target_address = res.target_address;
    assign m_fill_value     = res.fill_value;
    assign m_run_length     = res.run_length;
    assign m_needed_size    = res.needed_size;
    assign m_cut_valid      = res.cut_valid;
    assign m_cut_size       = res.cut_size;
    assign m_is_last        = res.is_last;

endmodule

`default_nettype wire

// File: dv/tb_ips_patch_stream_parser_unit.sv
// Testbench for the IPS patch stream parser: byte-level predictor and checker.
`timescale 1ns / 100ps

module tb_ips_patch_stream_parser_unit;
    import ips_psp_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          BYTES_PER_MODE = 133;
    localparam int          SETTLE_CYCLES = 20;
    localparam logic [39:0] PATCH_SIG     = "PATCH";

    typedef enum logic [3:0] {
        PS_HEADER, PS_ADDR, PS_LEN, PS_DATA, PS_RUNLEN,
        PS_RUNVAL, PS_TRAILER, PS_TAILDONE, PS_SKIP
    } parse_phase_e;

    typedef struct {
        logic [7:0] data;
        bit         last;
        bit         drain_first;
    } patch_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_patch_byte = 8'h00;
    logic        s_final_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [23:0] m_target_address;
    logic [7:0]  m_fill_value;
    logic [15:0] m_run_length;
    logic [24:0] m_needed_size;
    logic        m_cut_valid;
    logic [23:0] m_cut_size;
    logic        m_is_last;

    ips_patch_stream_parser_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_patch_byte     (s_patch_byte),
        .s_final_byte     (s_final_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_target_address (m_target_address),
        .m_fill_value     (m_fill_value),
        .m_run_length     (m_run_length),
        .m_needed_size    (m_needed_size),
        .m_cut_valid      (m_cut_valid),
        .m_cut_size       (m_cut_size),
        .m_is_last        (m_is_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    patch_item_t pending_bytes[$];
    psp_result_t expected_results[$];
    logic [7:0]  file_buf[$];
    int          errors = 0;
    int          bytes_queued = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          step_count;

    // predictor state
    parse_phase_e phase_q = PS_HEADER;
    logic [2:0]   idx_q = '0;
    logic [23:0]  rec_addr = '0;
    logic [15:0]  rec_len = '0;
    logic [15:0]  data_off = '0;
    logic [15:0]  run_cnt = '0;
    logic [24:0]  need_max = '0;
    logic [23:0]  trail_val = '0;

    task automatic clear_parser();
        phase_q   = PS_HEADER;
        idx_q     = '0;
        rec_addr  = '0;
        rec_len   = '0;
        data_off  = '0;
        run_cnt   = '0;
        need_max  = '0;
        trail_val = '0;
    endtask

    task automatic add_result(input logic [2:0] kind, input logic [23:0] addr,
                              input logic [7:0] val, input logic [15:0] run,
                              input logic [24:0] need, input logic cv,
                              input logic [23:0] cs);
        psp_result_t r;
        r.kind           = kind;
        r.target_address = addr;
        r.fill_value     = val;
        r.run_length     = run;
        r.needed_size    = need;
        r.cut_valid      = cv;
        r.cut_size       = cs;
        r.is_last        = 1'b0;
        expected_results.push_back(r);
        step_count++;
    endtask

    task automatic grow_need(input logic [15:0] len);
        logic [24:0] span_end;
        span_end = {1'b0, rec_addr} + {9'b0, len};
        if (span_end > need_max) need_max = span_end;
    endtask

    // Advance the parser by one accepted byte and queue the results it causes.
    task automatic predict_patch_byte(input logic [7:0] b, input logic fin);
        psp_result_t tail;
        step_count = 0;
        case (phase_q)
            PS_HEADER: begin
                if (b != PATCH_SIG[39 - 8 * idx_q -: 8]) begin
                    add_result(KIND_BAD_HDR, '0, '0, '0, '0, 1'b0, '0);
                    phase_q = PS_SKIP;
                end else if (idx_q == HDR_LEN - 1) begin
                    idx_q   = '0;
                    phase_q = PS_ADDR;
                end else begin
                    idx_q++;
                end
            end
            PS_ADDR: begin
                rec_addr = {rec_addr[15:0], b};
                if (idx_q == ADDR_BYTES - 1) begin
                    idx_q = '0;
                    if (rec_addr == EOF_MARK) begin
                        trail_val = '0;
                        phase_q   = PS_TRAILER;
                    end else begin
                        rec_len = '0;
                        phase_q = PS_LEN;
                    end
                end else begin
                    idx_q++;
                end
            end
            PS_LEN: begin
                rec_len = {rec_len[7:0], b};
                if (idx_q == LEN_BYTES - 1) begin
                    idx_q = '0;
                    if (rec_len != 0) begin
                        data_off = '0;
                        phase_q  = PS_DATA;
                    end else begin
                        run_cnt = '0;
                        phase_q = PS_RUNLEN;
                    end
                end else begin
                    idx_q++;
                end
            end
            PS_DATA: begin
                add_result(KIND_WRITE, rec_addr + {8'b0, data_off}, b, '0, '0, 1'b0, '0);
                data_off++;
                if (data_off == rec_len) begin
                    grow_need(rec_len);
                    phase_q = PS_ADDR;
                end
            end
            PS_RUNLEN: begin
                run_cnt = {run_cnt[7:0], b};
                if (idx_q == LEN_BYTES - 1) begin
                    idx_q   = '0;
                    phase_q = PS_RUNVAL;
                end else begin
                    idx_q++;
                end
            end
            PS_RUNVAL: begin
                add_result(KIND_FILL, rec_addr, b, run_cnt, '0, 1'b0, '0);
                grow_need(run_cnt);
                phase_q = PS_ADDR;
            end
            PS_TRAILER: begin
                trail_val = {trail_val[15:0], b};
                if (idx_q == TRAIL_BYTES - 1) begin
                    idx_q   = '0;
                    phase_q = PS_TAILDONE;
                end else begin
                    idx_q++;
                end
            end
            default: ;
        endcase
        if (fin) begin
            case (phase_q)
                PS_TRAILER:  add_result(KIND_FINISH, '0, '0, '0, need_max, 1'b0, '0);
                PS_TAILDONE: add_result(KIND_FINISH, '0, '0, '0, need_max, 1'b1, trail_val);
                PS_SKIP:     ;
                default:     add_result(KIND_CUT_SHORT, '0, '0, '0, '0, 1'b0, '0);
            endcase
            clear_parser();
        end
        if (step_count > 0) begin
            tail = expected_results.pop_back();
            tail.is_last = 1'b1;
            expected_results.push_back(tail);
        end
    endtask

    // ---------------- stimulus building ----------------

    task automatic add_header();
        for (int i = 0; i < 5; i++) file_buf.push_back(PATCH_SIG[39 - 8 * i -: 8]);
    endtask

    task automatic add24(input logic [23:0] v);
        file_buf.push_back(v[23:16]);
        file_buf.push_back(v[15:8]);
        file_buf.push_back(v[7:0]);
    endtask

    task automatic add16(input logic [15:0] v);
        file_buf.push_back(v[15:8]);
        file_buf.push_back(v[7:0]);
    endtask

    // Move the file under construction to the driver queue; last byte flagged final.
    task automatic flush_file(input bit drain);
        patch_item_t item;
        for (int i = 0; i < file_buf.size(); i++) begin
            item.data        = file_buf[i];
            item.last        = (i == file_buf.size() - 1);
            item.drain_first = drain && (i == 0);
            pending_bytes.push_back(item);
        end
        bytes_queued += file_buf.size();
        file_buf.delete();
    endtask

    task automatic directed_files();
        // wrapping writes, maximal fill span, full trailer plus an ignored extra byte
        add_header();
        add24(24'hFFFFFF); add16(16'h0002);
        file_buf.push_back(8'h00); file_buf.push_back(8'hFF);
        add24(24'hFFFFFF); add16(16'h0000); add16(16'hFFFF); file_buf.push_back(8'h5A);
        add24(EOF_MARK); add24(24'h123456); file_buf.push_back(8'h99);
        flush_file(1'b0);
        // bad header, later bytes ignored, final emits nothing
        file_buf.push_back(8'h50); file_buf.push_back(8'h58); file_buf.push_back(8'h00);
        flush_file(1'b0);
        // zero-length fill run, then partial trailer
        add_header();
        add24(24'h000100); add16(16'h0000); add16(16'h0000); file_buf.push_back(8'h77);
        add24(EOF_MARK); file_buf.push_back(8'h41);
        flush_file(1'b0);
        // final byte completes a write and also cuts the file short
        add_header();
        add24(24'h000010); add16(16'h0001); file_buf.push_back(8'hC3);
        flush_file(1'b1);
        // ends inside the header
        file_buf.push_back(8'h50); file_buf.push_back(8'h41);
        flush_file(1'b0);
    endtask

    task automatic random_file(input bit drain);
        int          style;
        int          nrec;
        int          len;
        int          cut;
        logic [23:0] addr;
        logic [7:0]  scrap;
        style = $urandom_range(99);
        if (style < 8) begin
            // noise
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) file_buf.push_back(8'($urandom));
        end else begin
            add_header();
            if (style < 16) file_buf[$urandom_range(4)] = 8'($urandom);
            nrec = $urandom_range(0, 4);
            for (int r = 0; r < nrec; r++) begin
                addr = 24'($urandom);
                if ($urandom_range(3) == 0) addr = 24'hFFFFFF - 24'($urandom_range(3));
                add24(addr);
                if ($urandom_range(2) == 0) begin
                    add16(16'h0000);
                    add16($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3)));
                    file_buf.push_back(8'($urandom));
                end else begin
                    len = $urandom_range(1, 4);
                    add16(16'(len));
                    for (int i = 0; i < len; i++) file_buf.push_back(8'($urandom));
                end
            end
            if (style < 90) begin
                add24(EOF_MARK);
                len = $urandom_range(0, 5);
                for (int i = 0; i < len; i++) file_buf.push_back(8'($urandom));
            end
            // sometimes the file stops at a random point
            if ($urandom_range(9) == 0 && file_buf.size() > 1) begin
                cut = $urandom_range(1, file_buf.size() - 1);
                while (file_buf.size() > cut) scrap = file_buf.pop_back();
            end
        end
        flush_file(drain);
    endtask

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_patch_byte(s_patch_byte, s_final_byte);
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
                    !(pending_bytes[0].drain_first && expected_results.size() != 0)) begin
                    s_valid      <= 1'b1;
                    s_patch_byte <= pending_bytes[0].data;
                    s_final_byte <= pending_bytes[0].last;
                    pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        psp_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none actual kind %0d",
                             $time, m_kind);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("target_address", want.target_address, m_target_address);
                    check_field("fill_value", want.fill_value, m_fill_value);
                    check_field("run_length", want.run_length, m_run_length);
                    check_field("needed_size", want.needed_size, m_needed_size);
                    check_field("cut_valid", want.cut_valid, m_cut_valid);
                    check_field("cut_size", want.cut_size, m_cut_size);
                    check_field("is_last", want.is_last, m_is_last);
                end
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_ips_patch_stream_parser_unit: FAIL");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 85 : 0;
            rx_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 6 : 0;
            if (mode == 0) directed_files();
            random_file(mode == 2);
            while (bytes_queued < (mode + 1) * BYTES_PER_MODE)
                random_file($urandom_range(4) == 0);
            while (pending_bytes.size() != 0) @(posedge aclk);
        end
        while (s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_ips_patch_stream_parser_unit: PASS");
        end else begin
            $display("tb_ips_patch_stream_parser_unit: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/ips_psp_pkg.sv
rtl/core/ips_psp_parser.sv
rtl/core/ips_psp_outq.sv
rtl/core/ips_patch_stream_parser_unit.sv
dv/tb_ips_patch_stream_parser_unit.sv
